FILE: design/adcfc_pkg.sv
// ----------------------------------------------------------------------------
// adcfc_pkg: shared constants and types
// Widths, op codes, status codes and sizes of the averaging history for the
// converter frame capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package adcfc_pkg;

    // sizes
    localparam int CHANNELS      = 4;
    localparam int AVG_LOG2      = 3;              // history depth is a power of two
    localparam int AVERAGE_DEPTH = 1 << AVG_LOG2;
    localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_ADDR_W   = CH_W + AVG_LOG2;
    localparam int HIST_DEPTH    = 1 << HIST_ADDR_W;

    // field widths
    localparam int OP_W     = 2;
    localparam int RAW_W    = 24;
    localparam int STATUS_W = 8;
    localparam int RCH_W    = 3;
    localparam int CODE_W   = 21;
    localparam int SAMPLE_W = 25;
    localparam int SUM_W    = CODE_W + AVG_LOG2;
    localparam int ERR_W    = 4;
    localparam int RUN_W    = 2;
    localparam int FR_W     = 2;
    localparam int GCH_W    = 3;

    localparam logic [RCH_W:0] CH_LIMIT = (RCH_W + 1)'(CHANNELS);

    // ops
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    // converter status decode
    localparam int            STATUS_ERR_BIT = 7;
    localparam logic [2:0]    ACCEPT_CODE    = 3'd4;
    localparam logic [ERR_W-1:0] ERROR_LIMIT = 4'd10;

    // sampling state
    localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
    localparam logic [RUN_W-1:0] RUN_WAIT    = 2'd1;
    localparam logic [RUN_W-1:0] RUN_READY   = 2'd2;

    // frame outcome
    localparam logic [FR_W-1:0] FR_ACCEPTED = 2'd0;
    localparam logic [FR_W-1:0] FR_REJECTED = 2'd1;
    localparam logic [FR_W-1:0] FR_IGNORED  = 2'd2;
    localparam logic [FR_W-1:0] FR_STOPPED  = 2'd3;

    typedef struct packed {
        logic                     granted;
        logic [FR_W-1:0]          frame_result;
        logic signed [CODE_W-1:0] code;
    } result_t;

endpackage

`default_nettype wire

FILE: design/adcfc_ram.sv
// ----------------------------------------------------------------------------
// adcfc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module adcfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/adc_frame_capture_moving_average.sv
// ----------------------------------------------------------------------------
// adc_frame_capture_moving_average: converter frame capture with averaging
//
//   channel | direction | handshake         | carries
//   --------+-----------+-------------------+---------------------------------
//   s_      | in        | s_valid / s_ready | op, raw code, status, read request
//   m_      | out       | m_valid / m_ready | grant, channel, code, status
//   cfg_    | in        | cfg_we            | bias offset
//
// start, frame, acquire and unfiltered reads go from idle to push; a
// filtered read first passes read, write and average, for the registered
// history ram read and the read-modify-write of the per-channel running sum.
// reset (aresetn low, synchronous) stops sampling, clears counters, the bias,
// stored sample, running sums, ring positions and history valid bits.
// the result sits in an output register; a new word is taken while it waits,
// and only a second result waits for m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_frame_capture_moving_average (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_we,
    input  wire logic [adcfc_pkg::RAW_W-1:0]          cfg_wdata,
    // input words
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [adcfc_pkg::OP_W-1:0]           s_op,
    input  wire logic [adcfc_pkg::RAW_W-1:0]          s_raw_code,
    input  wire logic [adcfc_pkg::STATUS_W-1:0]       s_status_byte,
    input  wire logic [adcfc_pkg::RCH_W-1:0]          s_read_channel,
    input  wire logic                                 s_use_filter,
    // result words
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_granted,
    output logic signed [adcfc_pkg::GCH_W-1:0]        m_granted_channel,
    output logic signed [adcfc_pkg::CODE_W-1:0]       m_code_value,
    output logic [adcfc_pkg::FR_W-1:0]                m_frame_result,
    output logic [adcfc_pkg::RUN_W-1:0]               m_sampling_state
);

    import adcfc_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;   // history read issued
    localparam logic [2:0] ST_WRITE = 3'd2;   // old entry back, write new, update sum
    localparam logic [2:0] ST_AVG   = 3'd3;   // divide updated sum
    localparam logic [2:0] ST_PUSH  = 3'd4;   // hand result to output register

    logic [2:0]                state_reg, state_next;
    logic [RUN_W-1:0]          run_reg, run_next;
    logic [ERR_W-1:0]          err_reg, err_next;
    logic                      lastv_reg, lastv_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [RAW_W-1:0]          bias_reg;
    result_t                   res_reg, res_next;
    logic signed [CODE_W-1:0]  code_reg, code_next;
    logic [CH_W-1:0]           ch_reg, ch_next;

    // per-channel ring position and running sum of the history entries
    logic [AVG_LOG2-1:0]       pos_reg [CHANNELS];
    logic signed [SUM_W-1:0]   sum_reg [CHANNELS];

    // history entries never written read as zero
    logic [HIST_DEPTH-1:0]     hist_vld_reg;
    logic                      vld_q_reg;

    logic                      m_valid_reg;
    logic                      m_granted_reg;
    logic signed [GCH_W-1:0]   m_gch_reg;
    logic signed [CODE_W-1:0]  m_code_reg;
    logic [FR_W-1:0]           m_fr_reg;
    logic [RUN_W-1:0]          m_run_reg;

    logic [HIST_ADDR_W-1:0]    hist_addr;
    logic [CODE_W-1:0]         hist_rdata;
    logic                      hist_we;
    logic signed [CODE_W-1:0]  old_entry;
    logic signed [SUM_W-1:0]   sum_cur;
    logic signed [SUM_W-1:0]   sum_upd;
    logic signed [SUM_W-1:0]   sum_adj;
    logic signed [CODE_W-1:0]  avg_code;

    logic                      frame_ok;
    logic                      chan_ok;
    logic [ERR_W-1:0]          err_inc;
    logic signed [SAMPLE_W-1:0] sample_shift;
    logic signed [CODE_W-1:0]  read_code;
    logic                      out_free;
    logic                      filt_accept;

    // ---------------- decode of the incoming word ----------------
    assign frame_ok = !s_status_byte[STATUS_ERR_BIT] && (s_status_byte[2:0] == ACCEPT_CODE);
    assign chan_ok  = ({1'b0, s_read_channel} < CH_LIMIT);
    assign err_inc  = err_reg + 1'b1;

    // arithmetic shift by 4 is floor division, same as the signed rounding rule
    assign sample_shift = sample_reg >>> 4;
    // only channel 0 is ever written by frames; other channels read zero
    assign read_code = (s_read_channel == '0) ? sample_shift[CODE_W-1:0] : '0;

    assign filt_accept = s_valid && s_ready && (s_op == OP_READ) && chan_ok && s_use_filter;

    // ---------------- history ram and running sum ----------------
    assign hist_addr = {ch_reg, pos_reg[ch_reg]};
    assign hist_we   = (state_reg == ST_WRITE);

    adcfc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (hist_we),
        .waddr (hist_addr),
        .wdata (code_reg),
        .raddr (hist_addr),
        .rdata (hist_rdata)
    );

    assign old_entry = vld_q_reg ? signed'(hist_rdata) : '0;
    assign sum_cur   = sum_reg[ch_reg];
    // replace the oldest entry: add the new code, drop the one it overwrites
    assign sum_upd   = sum_cur + SUM_W'(code_reg) - SUM_W'(old_entry);
    // divide by the depth, truncated toward zero
    assign sum_adj   = sum_cur + (sum_cur[SUM_W-1] ? SUM_W'(AVERAGE_DEPTH - 1) : '0);
    assign avg_code  = CODE_W'(sum_adj >>> AVG_LOG2);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next  = state_reg;
        run_next    = run_reg;
        err_next    = err_reg;
        lastv_next  = lastv_reg;
        sample_next = sample_reg;
        res_next    = res_reg;
        code_next   = code_reg;
        ch_next     = ch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    ch_next    = s_read_channel[CH_W-1:0];
                    state_next = ST_PUSH;
                    unique case (s_op)
                        OP_START: begin
                            run_next = RUN_WAIT;
                            err_next = '0;
                        end
                        OP_FRAME: begin
                            priority if (run_reg == RUN_STOPPED) begin
                                res_next.frame_result = FR_IGNORED;
                            end else if (frame_ok) begin
                                sample_next = signed'({1'b0, s_raw_code})
                                            - signed'({1'b0, bias_reg});
                                lastv_next  = 1'b1;
                                run_next    = RUN_READY;
                                err_next    = '0;
                                res_next.frame_result = FR_ACCEPTED;
                            end else if (err_inc >= ERROR_LIMIT) begin
                                run_next = RUN_STOPPED;
                                err_next = '0;
                                res_next.frame_result = FR_STOPPED;
                            end else begin
                                err_next = err_inc;
                                res_next.frame_result = FR_REJECTED;
                            end
                        end
                        OP_ACQUIRE: begin
                            if (run_reg == RUN_READY) begin
                                res_next.granted = 1'b1;
                                run_next         = RUN_WAIT;
                            end
                        end
                        OP_READ: begin
                            if (chan_ok) begin
                                res_next.code = read_code;
                                if (s_use_filter) begin
                                    code_next  = read_code;
                                    state_next = ST_READ;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_AVG;
            ST_AVG: begin
                res_next.code = avg_code;
                state_next    = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_reg      <= RUN_STOPPED;
            err_reg      <= '0;
            lastv_reg    <= 1'b0;
            sample_reg   <= '0;
            bias_reg     <= '0;
            hist_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                pos_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            run_reg    <= run_next;
            err_reg    <= err_next;
            lastv_reg  <= lastv_next;
            sample_reg <= sample_next;
            if (cfg_we) begin
                bias_reg <= cfg_wdata;
            end
            if (state_reg == ST_WRITE) begin
                hist_vld_reg[hist_addr] <= 1'b1;
                sum_reg[ch_reg]         <= sum_upd;
                pos_reg[ch_reg]         <= pos_reg[ch_reg] + 1'b1;
            end
            if (state_reg == ST_PUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_reg   <= res_next;
        code_reg  <= code_next;
        ch_reg    <= ch_next;
        vld_q_reg <= hist_vld_reg[hist_addr];
        if (state_reg == ST_PUSH && out_free) begin
            m_granted_reg <= res_reg.granted;
            m_fr_reg      <= res_reg.frame_result;
            m_code_reg    <= res_reg.code;
            m_gch_reg     <= lastv_reg ? '0 : '1;
            m_run_reg     <= run_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted         = m_granted_reg;
    assign m_granted_channel = m_gch_reg;
    assign m_code_value      = m_code_reg;
    assign m_frame_result    = m_fr_reg;
    assign m_sampling_state  = m_run_reg;

    // ---------------- checks ----------------
    // the error count clears when it reaches the limit, so it never holds it
    a_err_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg < ERROR_LIMIT)
        else $error("error count reached limit");

    // a successful acquire always leaves sampling waiting
    a_grant_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted) |-> (m_sampling_state == RUN_WAIT))
        else $error("grant without waiting state");

    // a frame that stopped sampling reports the stopped state
    a_stop_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_result == FR_STOPPED) |-> (m_sampling_state == RUN_STOPPED))
        else $error("stop not reflected in sampling state");

    // a filtered read goes through the history read
    a_filter_path: assert property (@(posedge aclk) disable iff (!aresetn)
        filt_accept |=> (state_reg == ST_READ))
        else $error("filtered read skipped history");

endmodule

`default_nettype wire

FILE: test/adc_frame_capture_moving_average_tb.sv
// ----------------------------------------------------------------------------
// adc_frame_capture_moving_average_tb: self-checking bench for frame capture
// A directed table (reset state, code extremes, error stop, channel limits)
// and then random traffic in phases with different bias offsets. Every result
// word is compared field by field against its table entry or an in-bench
// model of the capture, error counting and per-channel ring average.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_frame_capture_moving_average_tb;

    import adcfc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 12;      // filtered read is the slowest word
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 1950;
    localparam int PHASES       = 6;

    // frame_result sits at the accepted code for every op that is not a frame
    localparam logic [FR_W-1:0]  FR_NONE   = FR_ACCEPTED;
    // granted_channel before any frame has been accepted (-1)
    localparam logic [GCH_W-1:0] GCH_NONE  = '1;
    localparam logic [GCH_W-1:0] GCH_FIRST = '0;

    typedef struct packed {
        logic                     granted;
        logic [GCH_W-1:0]         gch;
        logic signed [CODE_W-1:0] code;
        logic [FR_W-1:0]          frame_result;
        logic [RUN_W-1:0]         run_state;
    } result_word_t;

    typedef struct {
        bit                  is_cfg;
        logic [RAW_W-1:0]    bias;
        logic [OP_W-1:0]     op;
        logic [RAW_W-1:0]    raw;
        logic [STATUS_W-1:0] status;
        logic [RCH_W-1:0]    rch;
        logic                filt;
        bit                  typed;
        result_word_t        want;
    } stim_row_t;

    // dut ports
    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_we;
    logic [RAW_W-1:0]           cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [OP_W-1:0]            s_op;
    logic [RAW_W-1:0]           s_raw_code;
    logic [STATUS_W-1:0]        s_status_byte;
    logic [RCH_W-1:0]           s_read_channel;
    logic                       s_use_filter;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_granted;
    logic signed [GCH_W-1:0]    m_granted_channel;
    logic signed [CODE_W-1:0]   m_code_value;
    logic [FR_W-1:0]            m_frame_result;
    logic [RUN_W-1:0]           m_sampling_state;

    // model of the capture state
    logic [RAW_W-1:0]           bias_q;
    logic [RUN_W-1:0]           run_q;
    int                         err_q;
    bit                         seen_q;
    logic signed [SAMPLE_W-1:0] sample_q [CHANNELS];
    logic signed [CODE_W-1:0]   hist_q [CHANNELS][AVERAGE_DEPTH];
    logic [AVG_LOG2-1:0]        pos_q [CHANNELS];

    result_word_t               pending_results [$];
    stim_row_t                  stim_rows [$];
    int                         mismatch_count = 0;
    int                         cycle_count = 0;
    bit                         quiet = 1'b0;     // no idling on either side

    adc_frame_capture_moving_average dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_raw_code        (s_raw_code),
        .s_status_byte     (s_status_byte),
        .s_read_channel    (s_read_channel),
        .s_use_filter      (s_use_filter),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted         (m_granted),
        .m_granted_channel (m_granted_channel),
        .m_code_value      (m_code_value),
        .m_frame_result    (m_frame_result),
        .m_sampling_state  (m_sampling_state)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("adc_frame_capture_moving_average_tb NOT OK");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // advance the model by one accepted word and build its result word
    task automatic capture_predict(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                                   input logic [STATUS_W-1:0] status,
                                   input logic [RCH_W-1:0] rch, input logic filt,
                                   output result_word_t r);
        longint              acc;
        logic [AVG_LOG2-1:0] slot;
        logic [CH_W-1:0]     ch;
        r = '0;
        case (op)
            OP_START: begin
                // also drops a pending ready sample
                run_q = RUN_WAIT;
                err_q = 0;
            end
            OP_FRAME: begin
                if (run_q == RUN_STOPPED) begin
                    r.frame_result = FR_IGNORED;
                end else if (!status[STATUS_ERR_BIT] && status[2:0] == ACCEPT_CODE) begin
                    // raw code minus bias, always lands in slot 0
                    sample_q[0] = $signed({1'b0, raw}) - $signed({1'b0, bias_q});
                    seen_q = 1'b1;
                    run_q = RUN_READY;
                    err_q = 0;
                    r.frame_result = FR_ACCEPTED;
                end else begin
                    err_q++;
                    if (err_q >= ERROR_LIMIT) begin
                        run_q = RUN_STOPPED;
                        err_q = 0;
                        r.frame_result = FR_STOPPED;
                    end else begin
                        r.frame_result = FR_REJECTED;
                    end
                end
            end
            OP_ACQUIRE: begin
                if (run_q == RUN_READY) begin
                    r.granted = 1'b1;
                    run_q = RUN_WAIT;
                end
            end
            default: begin
                // read: channels past the last one give zero and leave history alone
                if (rch < CHANNELS) begin
                    ch = rch[CH_W-1:0];
                    r.code = CODE_W'(sample_q[ch] >>> 4);
                    if (filt) begin
                        slot = pos_q[ch];
                        hist_q[ch][slot] = r.code;
                        pos_q[ch] = slot + 1'b1;
                        acc = 0;
                        for (int i = 0; i < AVERAGE_DEPTH; i++) begin
                            acc += hist_q[ch][i];
                        end
                        // signed division truncates toward zero
                        r.code = CODE_W'(acc / AVERAGE_DEPTH);
                    end
                end
            end
        endcase
        r.gch = seen_q ? GCH_FIRST : GCH_NONE;
        r.run_state = run_q;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                           input logic [STATUS_W-1:0] status, input logic [RCH_W-1:0] rch,
                           input logic filt, input bit typed, input logic granted,
                           input logic [GCH_W-1:0] gch, input logic [CODE_W-1:0] code,
                           input logic [FR_W-1:0] fr, input logic [RUN_W-1:0] run);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.bias = '0;
        row.op = op;
        row.raw = raw;
        row.status = status;
        row.rch = rch;
        row.filt = filt;
        row.typed = typed;
        row.want = '{granted, gch, code, fr, run};
        stim_rows.push_back(row);
    endtask

    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // drive one input word, hold it until taken, then log what should come back
    task automatic send_word(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                             input logic [STATUS_W-1:0] status, input logic [RCH_W-1:0] rch,
                             input logic filt, input bit typed, input result_word_t fixed);
        result_word_t predicted;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_op           <= op;
        s_raw_code     <= raw;
        s_status_byte  <= status;
        s_read_channel <= rch;
        s_use_filter   <= filt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        capture_predict(op, raw, status, rch, filt, predicted);
        pending_results.push_back(typed ? fixed : predicted);
    endtask

    // let every outstanding word come back, plus some slack
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bias(input logic [RAW_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        bias_q = value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // result side: compare each word taken against the oldest expectation
    always @(posedge aclk) begin : result_check
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result word with nothing expected", m_code_value, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_granted !== want.granted)
                    note_mismatch("granted", m_granted, want.granted);
                if (m_granted_channel !== want.gch)
                    note_mismatch("granted_channel", m_granted_channel, $signed(want.gch));
                if (m_code_value !== want.code)
                    note_mismatch("code_value", m_code_value, want.code);
                if (m_frame_result !== want.frame_result)
                    note_mismatch("frame_result", m_frame_result, want.frame_result);
                if (m_sampling_state !== want.run_state)
                    note_mismatch("sampling_state", m_sampling_state, want.run_state);
            end
        end
    end

    // result side back-pressure: stall bursts between ready stretches
    initial begin : sink_pacing
        int n;
        m_ready = 1'b0;
        forever begin
            if (quiet) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 7);
                repeat (n) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t           cfg_row;
        result_word_t        blank;
        logic [RAW_W-1:0]    bias;
        logic [OP_W-1:0]     op;
        logic [RAW_W-1:0]    raw;
        logic [STATUS_W-1:0] status;
        logic [RCH_W-1:0]    rch;
        logic                filt;
        int                  sent;
        int                  burst;
        int                  pick;

        blank = '0;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_op           = OP_START;
        s_raw_code     = '0;
        s_status_byte  = '0;
        s_read_channel = '0;
        s_use_filter   = 1'b0;

        // model reset
        bias_q = '0;
        run_q  = RUN_STOPPED;
        err_q  = 0;
        seen_q = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            sample_q[c] = '0;
            pos_q[c] = '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++) hist_q[c][i] = '0;
        end

        // directed table: typed rows carry their expected word, the rest use the model
        //       op          raw          status  ch    filt typ gr    gch        code          fr           state
        add_row(OP_ACQUIRE, 24'h000000, 8'h04, 3'd0, 1'b0, 1, 1'b0, GCH_NONE,  21'd0,       FR_NONE,     RUN_STOPPED);
        // frame while stopped is ignored
        add_row(OP_FRAME,   24'hABCDEF, 8'h04, 3'd0, 1'b0, 1, 1'b0, GCH_NONE,  21'd0,       FR_IGNORED,  RUN_STOPPED);
        add_row(OP_READ,    24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_NONE,  21'd0,       FR_NONE,     RUN_STOPPED);
        add_row(OP_START,   24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_NONE,  21'd0,       FR_NONE,     RUN_WAIT);
        // largest raw code with zero bias
        add_row(OP_FRAME,   24'hFFFFFF, 8'h04, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_ACCEPTED, RUN_READY);
        add_row(OP_READ,    24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'h0FFFFF,  FR_NONE,     RUN_READY);
        add_row(OP_READ,    24'h000000, 8'h00, 3'd0, 1'b1, 0, 1'b0, GCH_FIRST, 21'd0,       FR_NONE,     RUN_READY);
        add_row(OP_ACQUIRE, 24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b1, GCH_FIRST, 21'd0,       FR_NONE,     RUN_WAIT);
        // channels never written read zero, and so do channels past the last
        add_row(OP_READ,    24'h000000, 8'h00, 3'd1, 1'b1, 1, 1'b0, GCH_FIRST, 21'd0,       FR_NONE,     RUN_WAIT);
        add_row(OP_READ,    24'h000000, 8'h00, 3'd7, 1'b1, 1, 1'b0, GCH_FIRST, 21'd0,       FR_NONE,     RUN_WAIT);
        add_row(OP_FRAME,   24'h123456, 8'h84, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        // start while running clears the error count
        add_row(OP_START,   24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_NONE,     RUN_WAIT);
        // ten bad frames in a row stop sampling
        add_row(OP_FRAME,   24'h000001, 8'h05, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000002, 8'hFF, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000003, 8'h80, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000004, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000005, 8'h03, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000006, 8'h06, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000007, 8'h07, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000008, 8'h85, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h000009, 8'h01, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_REJECTED, RUN_WAIT);
        add_row(OP_FRAME,   24'h00000A, 8'hC4, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_STOPPED,  RUN_STOPPED);
        // largest bias, zero raw code gives the most negative code
        cfg_row = '{is_cfg: 1'b1, bias: 24'hFFFFFF, op: OP_START, raw: '0, status: '0,
                    rch: '0, filt: 1'b0, typed: 1'b0, want: '0};
        stim_rows.push_back(cfg_row);
        add_row(OP_START,   24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_NONE,     RUN_WAIT);
        add_row(OP_FRAME,   24'h000000, 8'h7C, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'd0,       FR_ACCEPTED, RUN_READY);
        add_row(OP_READ,    24'h000000, 8'h00, 3'd0, 1'b0, 1, 1'b0, GCH_FIRST, 21'h100000,  FR_NONE,     RUN_READY);
        add_row(OP_READ,    24'h000000, 8'h00, 3'd0, 1'b1, 0, 1'b0, GCH_FIRST, 21'd0,       FR_NONE,     RUN_READY);

        // synchronous reset, released on a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // walk the directed table
        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                write_bias(stim_rows[i].bias);
            end else begin
                if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 7));
                send_word(stim_rows[i].op, stim_rows[i].raw, stim_rows[i].status,
                          stim_rows[i].rch, stim_rows[i].filt, stim_rows[i].typed,
                          stim_rows[i].want);
            end
        end

        // random phases, each with its own bias; the last one runs without idling
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       bias = '0;
                1:       bias = '1;
                2:       bias = 24'h800000;
                3:       bias = RAW_W'($urandom_range(0, 4095));
                default: bias = RAW_W'($urandom);
            endcase
            write_bias(bias);
            if (phase == PHASES - 1) quiet = 1'b1;
            sent = 0;
            while (sent < RANDOM_WORDS / PHASES) begin
                if (!quiet && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 7));
                if ($urandom_range(0, 99) < 3) begin
                    // run of bad frames, long enough to reach the error stop
                    burst = $urandom_range(10, 12);
                    repeat (burst) begin
                        send_word(OP_FRAME, RAW_W'($urandom), {1'b1, 7'($urandom)},
                                  RCH_W'($urandom), 1'($urandom), 1'b0, blank);
                    end
                    sent += burst;
                end else begin
                    pick = $urandom_range(0, 99);
                    // mostly restart when stopped so frames get past the first state
                    if (run_q == RUN_STOPPED && $urandom_range(0, 3) != 0) op = OP_START;
                    else if (pick < 5)  op = OP_START;
                    else if (pick < 45) op = OP_FRAME;
                    else if (pick < 65) op = OP_ACQUIRE;
                    else                op = OP_READ;
                    case ($urandom_range(0, 9))
                        0:       raw = '0;
                        1:       raw = '1;
                        default: raw = RAW_W'($urandom);
                    endcase
                    // good frames with random upper status bits, else any status
                    if ($urandom_range(0, 3) != 0) status = {1'b0, 4'($urandom), ACCEPT_CODE};
                    else                           status = STATUS_W'($urandom);
                    rch  = ($urandom_range(0, 2) == 0) ? RCH_W'($urandom) : '0;
                    filt = 1'($urandom);
                    send_word(op, raw, status, rch, filt, 1'b0, blank);
                    sent++;
                end
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("adc_frame_capture_moving_average_tb OK");
        end else begin
            $display("adc_frame_capture_moving_average_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: adc_frame_capture_moving_average.f
design/adcfc_pkg.sv
design/adcfc_ram.sv
design/adc_frame_capture_moving_average.sv
test/adc_frame_capture_moving_average_tb.sv
